// ----- rtl/core/frc_pkg.sv -----
`timescale 1ns / 1ps

package frc_pkg;

    // Width of the signed input fields and of the reduced numerator.
    localparam int WIDTH = 32;

    // One request beat: a signed fraction.
    typedef struct packed {
        logic signed [WIDTH-1:0] numer_in;
        logic signed [WIDTH-1:0] denom_in;
    } in_t;

    // One response beat: the fraction in lowest terms.
    typedef struct packed {
        logic signed [WIDTH-1:0] numer_out;
        logic        [WIDTH-2:0] denom_out;
    } out_t;

    // A classified item as it waits between the front and the back.
    typedef struct packed {
        logic             rneg;
        logic [WIDTH-1:0] nmag;
        logic [WIDTH-1:0] dmag;
    } entry_t;

    // Sequencer of the back part.
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_GCD   = 4'b0010,
        S_START = 4'b0100,
        S_WAIT  = 4'b1000
    } state_t;

endpackage

// ----- rtl/core/frc_front.sv -----
`timescale 1ns / 1ps

module frc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  frc_pkg::in_t    req_data,
    output logic            push_valid,
    input  logic            push_ready,
    output frc_pkg::entry_t push_data
);

    localparam int W = frc_pkg::WIDTH;

    logic            ent_valid_reg;
    logic            ent_valid_next;
    frc_pkg::entry_t ent_reg;
    frc_pkg::entry_t ent_next;

    logic [W-1:0] n_raw;
    logic [W-1:0] d_raw;
    logic         nneg;
    logic         dneg;
    logic         nzero;

    assign n_raw = req_data.numer_in;
    assign d_raw = req_data.denom_in;
    assign nneg  = n_raw[W-1];
    assign dneg  = d_raw[W-1];
    assign nzero = (n_raw == '0);

    // A zero numerator is turned into 0/1 up front, so the back part
    // reduces it like any other fraction and always ends with 0/1.
    always_comb
    begin
        ent_next.rneg = nzero ? 1'b0 : (nneg ^ dneg);
        ent_next.nmag = nneg ? (~n_raw + 1'b1) : n_raw;
        if (nzero)
        begin
            ent_next.dmag = W'(1);
        end
        else
        begin
            ent_next.dmag = dneg ? (~d_raw + 1'b1) : d_raw;
        end
    end

    assign req_ready  = !ent_valid_reg || push_ready;
    assign push_valid = ent_valid_reg;
    assign push_data  = ent_reg;

    always_comb
    begin
        ent_valid_next = ent_valid_reg;
        if (req_valid && req_ready)
        begin
            ent_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            ent_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else
        begin
            ent_valid_reg <= ent_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

// ----- rtl/core/frc_fifo.sv -----
`timescale 1ns / 1ps

module frc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  frc_pkg::entry_t push_data,
    output logic            pop_valid,
    input  logic            pop_ready,
    output frc_pkg::entry_t pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    frc_pkg::entry_t slot_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/core/frc_divider.sv -----
`timescale 1ns / 1ps

module frc_divider (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [frc_pkg::WIDTH-1:0]  dividend,
    input  logic [frc_pkg::WIDTH-1:0]  divisor,
    output logic                       busy,
    output logic [frc_pkg::WIDTH-1:0]  quotient
);

    localparam int W  = frc_pkg::WIDTH;
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  quo_reg;
    logic [W-1:0]  dvs_reg;
    logic [W:0]    diff;

    // Restoring division, one quotient bit per cycle.
    assign diff     = {rem_reg, quo_reg[W-1]} - {1'b0, dvs_reg};
    assign busy     = busy_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                rem_reg <= diff[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], quo_reg[W-1]};
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- rtl/core/frc_back.sv -----
`timescale 1ns / 1ps

module frc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  frc_pkg::entry_t pop_data,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output frc_pkg::out_t   rsp_data
);

    localparam int W  = frc_pkg::WIDTH;
    localparam int KW = $clog2(W);
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};

    frc_pkg::state_t state_reg;
    frc_pkg::state_t state_next;

    logic [W-1:0]  a_reg;
    logic [W-1:0]  a_next;
    logic [W-1:0]  b_reg;
    logic [W-1:0]  b_next;
    logic [KW-1:0] k_reg;
    logic [KW-1:0] k_next;
    logic [W-1:0]  g_reg;
    logic [W-1:0]  g_next;
    logic [W-1:0]  nmag_reg;
    logic [W-1:0]  dmag_reg;
    logic          rneg_reg;

    logic          out_valid_reg;
    logic          out_valid_next;
    frc_pkg::out_t out_reg;
    frc_pkg::out_t out_next;
    logic          load_out;

    logic          div_start;
    logic          busy_n;
    logic          busy_d;
    logic [W-1:0]  rn;
    logic [W-1:0]  rd;
    logic [W-1:0]  a_minus_b;
    logic [W-1:0]  b_minus_a;

    assign pop_ready = (state_reg == frc_pkg::S_IDLE);
    assign div_start = (state_reg == frc_pkg::S_START);
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;
    assign a_minus_b = a_reg - b_reg;
    assign b_minus_a = b_reg - a_reg;

    // The two quotients are formed side by side.
    frc_divider u_div_numer (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (nmag_reg),
        .divisor  (g_reg),
        .busy     (busy_n),
        .quotient (rn)
    );

    frc_divider u_div_denom (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dmag_reg),
        .divisor  (g_reg),
        .busy     (busy_d),
        .quotient (rd)
    );

    assign load_out = (state_reg == frc_pkg::S_WAIT) && !busy_n && !busy_d
                      && (!out_valid_reg || rsp_ready);

    // Sign goes on the numerator; magnitudes that do not fit are clamped.
    always_comb
    begin
        if (rneg_reg)
        begin
            out_next.numer_out = ~rn + 1'b1;
        end
        else
        begin
            out_next.numer_out = (rn > MAXPOS) ? MAXPOS : rn;
        end
        out_next.denom_out = (rd > MAXPOS) ? MAXPOS[W-2:0] : rd[W-2:0];
    end

    // Binary GCD: one halving or one subtract-and-halve per cycle, with the
    // shared power of two counted in k and put back at the end.
    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        g_next     = g_reg;
        unique case (state_reg)
            frc_pkg::S_IDLE:
            begin
                if (pop_valid)
                begin
                    a_next     = pop_data.nmag;
                    b_next     = pop_data.dmag;
                    k_next     = '0;
                    state_next = frc_pkg::S_GCD;
                end
            end
            frc_pkg::S_GCD:
            begin
                if (a_reg == '0 || b_reg == '0)
                begin
                    g_next     = (a_reg | b_reg) << k_reg;
                    state_next = frc_pkg::S_START;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 1'b1;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (a_reg >= b_reg)
                begin
                    a_next = a_minus_b >> 1;
                end
                else
                begin
                    b_next = b_minus_a >> 1;
                end
            end
            frc_pkg::S_START:
            begin
                state_next = frc_pkg::S_WAIT;
            end
            frc_pkg::S_WAIT:
            begin
                if (load_out)
                begin
                    state_next = frc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = frc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= frc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
        g_reg <= g_next;
        if (pop_valid && pop_ready)
        begin
            nmag_reg <= pop_data.nmag;
            dmag_reg <= pop_data.dmag;
            rneg_reg <= pop_data.rneg;
        end
        if (load_out)
        begin
            out_reg <= out_next;
        end
    end

endmodule

// ----- rtl/core/fraction_reduction.sv -----
// Reduces a signed fraction to lowest terms; one response beat per request beat, in order.
// The back works on one beat at a time: the binary GCD loop does one step per cycle, then
// the two dividers form both quotients and the result is loaded into the output register.
// The back takes the next beat once the last result is in the output register; the front keeps
// accepting into the queue, while it has room, as the back works and while a response waits.
// Reset (rst_n, asynchronous, active low) empties the queue and drops any pending response.
`timescale 1ns / 1ps

module fraction_reduction #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  frc_pkg::in_t  req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output frc_pkg::out_t rsp_data
);

    // Front to queue.
    logic            push_valid;
    logic            push_ready;
    frc_pkg::entry_t push_data;

    // Queue to back.
    logic            pop_valid;
    logic            pop_ready;
    frc_pkg::entry_t pop_data;

    // The front registers each request beat after splitting it into sign and
    // magnitudes, and it folds the zero-numerator case into the fraction 0/1.
    frc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req_data   (req_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // A short queue lets the front keep taking beats while the back iterates.
    frc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    // The back finds the GCD with a binary GCD loop, divides both magnitudes
    // by it with two bit-serial dividers, and holds the result in an output
    // register until the response beat is taken.
    frc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

endmodule

// ----- rtl/core/frc_checker.sv -----
`timescale 1ns / 1ps

module frc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input frc_pkg::in_t  req_data,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input frc_pkg::out_t rsp_data
);

    localparam int W = frc_pkg::WIDTH;
    localparam logic [W-2:0] DENOM_ONE = (W-1)'(1);
    localparam logic [W-1:0] NUMER_POS_ONE = W'(1);
    localparam logic [W-1:0] NUMER_NEG_ONE = '1;

    // A stalled response keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // A zero numerator always comes out as 0/1.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.numer_out == '0 |-> rsp_data.denom_out == DENOM_ONE)
        else $error("zero numerator without unit denominator");

    // A zero denominator leaves only the sign on the numerator.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.denom_out == '0 |->
            rsp_data.numer_out == NUMER_POS_ONE || rsp_data.numer_out == NUMER_NEG_ONE)
        else $error("zero denominator with numerator other than plus or minus one");

    // A stalled request keeps its valid and its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req_data))
        else $error("request changed while stalled");

endmodule

bind fraction_reduction frc_checker u_frc_checker (.*);
